/* sv/bwfa_pkg.sv */
// bwfa_pkg: types and constants for the best/worst fit block allocator
// request, response and block table entry layouts, status codes, sequencer states
// no dependencies
package bwfa_pkg;

  localparam int ADDR_BITS = 16;
  localparam logic [ADDR_BITS-1:0] POOL_SIZE_RESET = 16'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic FIT_BEST  = 1'b0;
  localparam logic FIT_WORST = 1'b1;

  typedef logic [2:0] status_t;

  localparam status_t ST_ALLOCATED  = 3'd0;
  localparam status_t ST_FREED      = 3'd1;
  localparam status_t ST_NO_FIT     = 3'd2;
  localparam status_t ST_NOT_FOUND  = 3'd3;
  localparam status_t ST_TABLE_FULL = 3'd4;

  typedef struct packed {
    logic                 op;
    logic [ADDR_BITS-1:0] request_size;
    logic                 fit_mode;
    logic [ADDR_BITS-1:0] free_address;
  } bwfa_req_t;

  typedef struct packed {
    status_t              status;
    logic [ADDR_BITS-1:0] granted_address;
  } bwfa_rsp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic                 is_free;
  } blk_entry_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_FNEXT,
    S_MERGE,
    S_SHIFT,
    S_SPLIT_HI,
    S_SPLIT_LO,
    S_DONE
  } state_t;

endpackage

/* sv/best_worst_fit_allocator.sv */
// best_worst_fit_allocator: address-ordered block table with best/worst fit and coalescing
// one table memory, one read and one write port, driven by a small sequencer
// depends on bwfa_pkg
//
//  channel | direction | payload     | transfer when
//  req     | in        | bwfa_req_t  | req_valid & req_ready
//  rsp     | out       | bwfa_rsp_t  | rsp_valid & rsp_ready
//  cfg     | in        | pool_size   | cfg_valid & cfg_ready
//
// one request at a time; the table memory port sets the pace, one entry a cycle
// allocate: scan of all block_count entries, then (unless the fit is exact) a shift up and the split writes
// free: scan up to the hit index, read of the next entry, merge write, then a shift down if a neighbour merged
// after reset and after each pool_size write, the init state writes the first table entry
// a finished response waits in the output register; the next request is taken meanwhile
module best_worst_fit_allocator
  import bwfa_pkg::*;
#(
  parameter int MAX_BLOCKS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  bwfa_req_t            req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output bwfa_rsp_t            rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ADDR_BITS-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  state_t               state, state_next;
  logic [CW-1:0]        count;
  logic [ADDR_BITS-1:0] pool_size;
  bwfa_req_t            req_q;
  logic [CW-1:0]        ptr;
  logic                 dv_q;
  logic [IW-1:0]        di_q;
  logic                 pend_q;
  logic [IW-1:0]        pend_addr;
  logic                 shift_up;
  logic                 found;
  logic [IW-1:0]        pick;
  logic [ADDR_BITS-1:0] bstart;
  logic [ADDR_BITS-1:0] bsize;
  logic [ADDR_BITS-1:0] psize;
  logic [ADDR_BITS-1:0] nsize;
  logic                 pf;
  logic                 nf;
  blk_entry_t           prev_q;
  bwfa_rsp_t            res;
  bwfa_rsp_t            rsp_q;
  logic                 rsp_valid_q;

  blk_entry_t           mem [MAX_BLOCKS];
  blk_entry_t           rd_data;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  blk_entry_t           wr_data;

  logic                 req_xfer;
  logic                 cfg_xfer;
  logic                 scan_done;
  logic                 hit;
  logic                 fits;
  logic                 shift_issue;
  logic                 has_next;
  logic [1:0]           drop;
  logic [IW-1:0]        tgt;
  logic [ADDR_BITS-1:0] msize;
  logic                 rsp_load;

  assign req_xfer  = req_valid && req_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign scan_done = !dv_q && (ptr >= count);
  assign hit       = dv_q && (rd_data.start == req_q.free_address) && !rd_data.is_free;
  assign fits      = dv_q && rd_data.is_free && (rd_data.size >= req_q.request_size) &&
                     (!found || ((req_q.fit_mode == FIT_WORST) ? (rd_data.size > bsize)
                                                                : (rd_data.size < bsize)));
  assign shift_issue = shift_up ? (ptr > CW'(pick)) : (ptr < count);
  assign has_next  = (CW'(pick) + CW'(1)) < count;
  assign drop      = {pf && nf, pf ^ nf};
  assign tgt       = pick - IW'(pf);
  assign msize     = bsize + (pf ? psize : '0) + (nf ? nsize : '0);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid_q || rsp_ready);
  assign rsp_valid = rsp_valid_q;
  assign rsp       = rsp_q;

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[ptr[IW-1:0]];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: begin
        if (cfg_xfer) begin
          state_next = S_INIT;
        end else if (req_xfer) begin
          if (req.op == OP_ALLOC && req.request_size == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (req_q.op == OP_FREE) begin
          if (hit) begin
            state_next = S_FNEXT;
          end else if (scan_done) begin
            state_next = S_DONE;
          end
        end else if (scan_done) begin
          if (!found) begin
            state_next = S_DONE;
          end else if (bsize == req_q.request_size) begin
            state_next = S_SPLIT_LO;
          end else if (count == CW'(MAX_BLOCKS)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SHIFT;
          end
        end
      end
      S_FNEXT: state_next = S_MERGE;
      S_MERGE: state_next = (pf || nf) ? S_SHIFT : S_DONE;
      S_SHIFT: begin
        if (!shift_issue && !pend_q) begin
          state_next = shift_up ? S_SPLIT_HI : S_DONE;
        end
      end
      S_SPLIT_HI: state_next = S_SPLIT_LO;
      S_SPLIT_LO: state_next = S_DONE;
      S_DONE: state_next = rsp_load ? S_IDLE : S_DONE;
      default: state_next = S_INIT;
    endcase
  end

  // handshakes and table writes
  always_comb begin
    req_ready = (state == S_IDLE) && !cfg_valid;
    cfg_ready = (state == S_IDLE);
    wr_en     = 1'b0;
    wr_addr   = pick;
    wr_data   = rd_data;
    unique case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '{start: '0, size: pool_size, is_free: 1'b1};
      end
      S_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = tgt;
        wr_data = '{start: bstart, size: msize, is_free: 1'b1};
      end
      S_SHIFT: begin
        wr_en   = pend_q;
        wr_addr = pend_addr;
        wr_data = rd_data;
      end
      S_SPLIT_HI: begin
        wr_en   = 1'b1;
        wr_addr = pick + IW'(1);
        wr_data = '{start: bstart + req_q.request_size,
                    size: bsize - req_q.request_size, is_free: 1'b1};
      end
      S_SPLIT_LO: begin
        wr_en   = 1'b1;
        wr_addr = pick;
        wr_data = '{start: bstart, size: req_q.request_size, is_free: 1'b0};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      count       <= CW'(1);
      pool_size   <= POOL_SIZE_RESET;
      dv_q        <= 1'b0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state  <= state_next;
      pend_q <= (state == S_SHIFT) && shift_issue;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state)
        S_INIT: count <= CW'(1);
        S_IDLE: begin
          dv_q <= 1'b0;
          if (cfg_xfer) begin
            pool_size <= cfg_data;
          end
        end
        S_SCAN: dv_q <= (ptr < count);
        S_SHIFT: begin
          if (!shift_issue && !pend_q && !shift_up) begin
            count <= count - CW'(drop);
          end
        end
        S_SPLIT_HI: count <= count + CW'(1);
        default: dv_q <= 1'b0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_q <= res;
    end
    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          req_q <= req;
          ptr   <= '0;
          found <= 1'b0;
          res   <= '{status: ST_NO_FIT, granted_address: '0};
        end
      end
      S_SCAN: begin
        if (ptr < count) begin
          ptr  <= ptr + CW'(1);
          di_q <= ptr[IW-1:0];
        end
        if (dv_q) begin
          prev_q <= rd_data;
        end
        if (req_q.op == OP_FREE) begin
          if (hit) begin
            pick  <= di_q;
            pf    <= (di_q != '0) && prev_q.is_free;
            bstart <= ((di_q != '0) && prev_q.is_free) ? prev_q.start : rd_data.start;
            bsize <= rd_data.size;
            psize <= prev_q.size;
          end else if (scan_done) begin
            res <= '{status: ST_NOT_FOUND, granted_address: '0};
          end
        end else begin
          if (fits) begin
            found  <= 1'b1;
            pick   <= di_q;
            bstart <= rd_data.start;
            bsize  <= rd_data.size;
          end
          if (scan_done) begin
            ptr      <= count - CW'(1);
            shift_up <= 1'b1;
            if (!found) begin
              res <= '{status: ST_NO_FIT, granted_address: '0};
            end else begin
              res <= '{status: ST_TABLE_FULL, granted_address: '0};
            end
          end
        end
      end
      S_FNEXT: begin
        nf    <= has_next && rd_data.is_free;
        nsize <= rd_data.size;
      end
      S_MERGE: begin
        ptr      <= CW'(pick) + CW'(1) + CW'(nf);
        shift_up <= 1'b0;
        res      <= '{status: ST_FREED, granted_address: '0};
      end
      S_SHIFT: begin
        if (shift_issue) begin
          pend_addr <= shift_up ? (ptr[IW-1:0] + IW'(1)) : (ptr[IW-1:0] - IW'(drop));
          ptr       <= shift_up ? (ptr - CW'(1)) : (ptr + CW'(1));
        end
      end
      S_SPLIT_LO: res <= '{status: ST_ALLOCATED, granted_address: bstart};
      default: begin
        res <= res;
      end
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CW'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_split_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT_HI) |=> (count == $past(count) + CW'(1)))
    else $error("split did not add an entry");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_ALLOCATED) |-> (rsp.granted_address == '0))
    else $error("address on a non-allocate response");

  a_pend_in_shift: assert property (@(posedge clk) disable iff (rst)
    pend_q |-> (state == S_SHIFT))
    else $error("shift write outside shift pass");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> (state != S_IDLE) && !req_ready)
    else $error("request transfer left block idle");

endmodule
